// File: hdl/piecewise_linear_keyframe_interp_defines.svh
// assertion helpers for the interpolator rtl
`ifndef PIECEWISE_LINEAR_KEYFRAME_INTERP_DEFINES_SVH
`define PIECEWISE_LINEAR_KEYFRAME_INTERP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PLKI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define PLKI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/plki_pkg.sv
package plki_pkg;

  localparam int MAX_KEYFRAMES_DEF = 16;
  localparam int RATIO_BITS = 17;
  localparam logic [RATIO_BITS-1:0] RATIO_ONE = 17'h10000;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] SRC_DEFAULT = 2'd0;
  localparam logic [1:0] SRC_FOUND   = 2'd1;
  localparam logic [1:0] SRC_BEYOND  = 2'd2;

  localparam logic REG_COUNT   = 1'b0;
  localparam logic REG_DEFAULT = 1'b1;

  // everything that rides alongside the ratio through the divider
  typedef struct packed {
    logic        interp;
    logic        use_ratio;
    logic [1:0]  src;
    logic [31:0] val;
    logic [31:0] ga;
    logic [31:0] gb;
  } div_side_t;

endpackage

// File: hdl/plki_if.sv
interface plki_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [3:0]  entry_index;
  logic [31:0] entry_radius;
  logic signed [31:0] entry_value;
  logic [31:0] query_distance;
  logic [15:0] radius_scale;

  modport source (output valid, mode, entry_index, entry_radius, entry_value,
                  query_distance, radius_scale, input ready);
  modport sink (input valid, mode, entry_index, entry_radius, entry_value,
                query_distance, radius_scale, output ready);
endinterface

interface plki_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic [1:0]  result_source;

  modport source (output valid, result_value, result_source, input ready);
  modport sink (input valid, result_value, result_source, output ready);
endinterface

// File: hdl/piecewise_linear_keyframe_interp.sv
// Piecewise linear keyframe interpolator.
// Input channel in_if: a beat with mode write stores one keyframe (radius and
// value) in slot entry_index and gives no result; a beat with mode query gives
// exactly one result beat on out_if with the interpolated value and its source.
// Keyframe count and default value are set over the apb port (0x0, 0x4) while
// no query is in flight, a rule on the user that the block does not enforce.
// Pipeline: the accepting edge loads the first of 22 register stages: radius
// scaling, compare and select (3), one stage per ratio bit of the pipelined
// divider (17), multiply and round (2); the result leaves the last stage.
// Throughput: one beat per cycle while out_if does not stall; the pipeline
// moves as one, and a new beat can be taken before earlier ones are through.
// When out_if stalls, every stage holds and in_if.ready drops until the
// result is taken; nothing is lost or repeated.
// Reset clears all valid bits and both registers (count 0, default 0); the
// keyframe table is not cleared and holds garbage until written.
`include "piecewise_linear_keyframe_interp_defines.svh"

module piecewise_linear_keyframe_interp #(
  parameter int MAX_KEYFRAMES = plki_pkg::MAX_KEYFRAMES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  plki_in_if.sink       in_if,
  plki_out_if.source    out_if,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int IW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
  localparam int NW = $clog2(MAX_KEYFRAMES + 1);

  logic        en;
  logic        acc_beat;
  logic        cfg_we;
  logic [4:0]  cnt_q;
  logic [31:0] dflt_q;

  logic [31:0] rad_q [MAX_KEYFRAMES];
  logic [31:0] val_q [MAX_KEYFRAMES];
  logic [31:0] sr_d  [MAX_KEYFRAMES];

  logic        s1_valid_q;
  logic [31:0] s1_sr_q   [MAX_KEYFRAMES];
  logic [31:0] s1_val_q  [MAX_KEYFRAMES];
  logic [31:0] s1_dist_q;
  logic [NW-1:0] s1_n_q;
  logic [31:0] s1_dflt_q;
  logic [NW-1:0] n_d;

  logic        s2_valid_q;
  logic [MAX_KEYFRAMES-1:0] s2_hit_q;
  logic [31:0] s2_sr_q   [MAX_KEYFRAMES];
  logic [31:0] s2_val_q  [MAX_KEYFRAMES];
  logic [31:0] s2_dist_q;
  logic [NW-1:0] s2_n_q;
  logic [31:0] s2_dflt_q;
  logic [MAX_KEYFRAMES-1:0] hit_d;

  logic        found;
  logic [IW-1:0] sel;
  logic [IW-1:0] prev;
  logic [IW-1:0] last;
  logic [31:0] ra;
  logic [31:0] rb;
  plki_pkg::div_side_t side_d;

  logic        s3_valid_q;
  logic [31:0] s3_num_q;
  logic [31:0] s3_den_q;
  plki_pkg::div_side_t s3_side_q;

  logic        dv_valid;
  logic [plki_pkg::RATIO_BITS-1:0] dv_ratio;
  plki_pkg::div_side_t dv_side;
  logic [31:0] res_value;

  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;
  assign acc_beat    = in_if.valid && in_if.ready;

  // configuration
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == plki_pkg::REG_DEFAULT) ? dflt_q : {27'd0, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      dflt_q <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == plki_pkg::REG_COUNT) begin
        cnt_q <= pwdata[4:0];
      end else begin
        dflt_q <= pwdata;
      end
    end
  end

  // keyframe table
  always_ff @(posedge clk_i) begin
    if (acc_beat && in_if.mode == plki_pkg::MODE_WRITE &&
        32'(in_if.entry_index) < 32'(MAX_KEYFRAMES)) begin
      rad_q[IW'(in_if.entry_index)] <= in_if.entry_radius;
      val_q[IW'(in_if.entry_index)] <= in_if.entry_value;
    end
  end

  // stage 1: scale every radius, one multiplier per slot
  for (genvar i = 0; i < MAX_KEYFRAMES; i++) begin : g_scale
    logic [47:0] prod;
    assign prod    = rad_q[i] * in_if.radius_scale;
    assign sr_d[i] = (prod[47:40] != 8'd0) ? 32'hFFFF_FFFF : prod[39:8];
  end

  assign n_d = (32'(cnt_q) > 32'(MAX_KEYFRAMES)) ? NW'(MAX_KEYFRAMES) : NW'(cnt_q);

  // stage 2: compare against the distance
  for (genvar i = 0; i < MAX_KEYFRAMES; i++) begin : g_cmp
    assign hit_d[i] = (32'(i) < 32'(s1_n_q)) && (s1_dist_q <= s1_sr_q[i]);
  end

  // stage 3: pick the first hit and set up the divide
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < MAX_KEYFRAMES; i++) begin
      if (!found && s2_hit_q[i]) begin
        found = 1'b1;
        sel   = IW'(i);
      end
    end
    prev = sel - IW'(1);
    last = IW'(s2_n_q - NW'(1));
    rb   = s2_sr_q[sel];
    ra   = s2_sr_q[prev];
    side_d.interp    = found && (sel != '0);
    side_d.use_ratio = found && (sel != '0) && (rb > ra) && (s2_dist_q > ra);
    side_d.ga        = s2_val_q[prev];
    side_d.gb        = s2_val_q[sel];
    if (s2_n_q == '0) begin
      side_d.src = plki_pkg::SRC_DEFAULT;
      side_d.val = s2_dflt_q;
    end else if (found) begin
      side_d.src = plki_pkg::SRC_FOUND;
      side_d.val = s2_val_q[sel];
    end else begin
      side_d.src = plki_pkg::SRC_BEYOND;
      side_d.val = s2_val_q[last];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= acc_beat && in_if.mode == plki_pkg::MODE_QUERY;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sr_q   <= sr_d;
      s1_val_q  <= val_q;
      s1_dist_q <= in_if.query_distance;
      s1_n_q    <= n_d;
      s1_dflt_q <= dflt_q;
      s2_hit_q  <= hit_d;
      s2_sr_q   <= s1_sr_q;
      s2_val_q  <= s1_val_q;
      s2_dist_q <= s1_dist_q;
      s2_n_q    <= s1_n_q;
      s2_dflt_q <= s1_dflt_q;
      s3_num_q  <= s2_dist_q - ra;
      s3_den_q  <= rb - ra;
      s3_side_q <= side_d;
    end
  end

  plki_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_valid_q),
    .num_i   (s3_num_q),
    .den_i   (s3_den_q),
    .side_i  (s3_side_q),
    .valid_o (dv_valid),
    .ratio_o (dv_ratio),
    .side_o  (dv_side)
  );

  plki_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (dv_valid),
    .ratio_i  (dv_ratio),
    .side_i   (dv_side),
    .valid_o  (out_if.valid),
    .value_o  (res_value),
    .source_o (out_if.result_source)
  );

  assign out_if.result_value = res_value;

  `PLKI_ASSERT_NOW(a_stall_blocks_input, out_if.valid && !out_if.ready, !in_if.ready,
    "input taken while output stalled")
  `PLKI_ASSERT_NEXT(a_count_write, cfg_we && paddr[2] == plki_pkg::REG_COUNT,
    cnt_q == $past(pwdata[4:0]), "keyframe count not written")
  `PLKI_ASSERT_NOW(a_source_code, out_if.valid,
    out_if.result_source == plki_pkg::SRC_DEFAULT || out_if.result_source == plki_pkg::SRC_FOUND
    || out_if.result_source == plki_pkg::SRC_BEYOND, "bad result source")
  `PLKI_ASSERT_NEXT(a_stall_holds_s1, !en && s1_valid_q, s1_valid_q,
    "query lost in stalled pipeline")

endmodule

// File: hdl/plki_div.sv
module plki_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [31:0]           num_i,
  input  logic [31:0]           den_i,
  input  plki_pkg::div_side_t   side_i,
  output logic                  valid_o,
  output logic [plki_pkg::RATIO_BITS-1:0] ratio_o,
  output plki_pkg::div_side_t   side_o
);

  localparam int Steps = plki_pkg::RATIO_BITS;

  logic                v_q    [Steps];
  logic [31:0]         rem_q  [Steps];
  logic [Steps-1:0]    quo_q  [Steps];
  logic [31:0]         den_q  [Steps];
  logic                ovf_q  [Steps];
  plki_pkg::div_side_t side_q [Steps];

  // one quotient bit per stage, msb first
  for (genvar j = 0; j < Steps; j++) begin : g_step
    logic                v_in;
    logic [31:0]         rem_in;
    logic [Steps-1:0]    quo_in;
    logic [31:0]         den_in;
    logic                ovf_in;
    logic                bit_in;
    plki_pkg::div_side_t side_in;
    logic [32:0]         shifted;
    logic                ge;
    logic [31:0]         rem_d;
    logic [Steps-1:0]    quo_d;

    if (j == 0) begin : g_first
      // quotient above 17 bits exactly when num >= 2*den
      assign v_in    = valid_i;
      assign rem_in  = {1'b0, num_i[31:1]};
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign ovf_in  = {1'b0, num_i} >= {den_i, 1'b0};
      assign bit_in  = num_i[0];
      assign side_in = side_i;
    end else begin : g_rest
      assign v_in    = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign den_in  = den_q[j-1];
      assign ovf_in  = ovf_q[j-1];
      assign bit_in  = 1'b0;
      assign side_in = side_q[j-1];
    end

    always_comb begin
      shifted = {rem_in, bit_in};
      ge      = shifted >= {1'b0, den_in};
      rem_d   = ge ? 32'(shifted - {1'b0, den_in}) : shifted[31:0];
      quo_d   = quo_in;
      quo_d[Steps-1-j] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        quo_q[j]  <= quo_d;
        den_q[j]  <= den_in;
        ovf_q[j]  <= ovf_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign ratio_o = ovf_q[Steps-1] ? plki_pkg::RATIO_ONE : quo_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

// File: hdl/plki_blend.sv
module plki_blend (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [plki_pkg::RATIO_BITS-1:0] ratio_i,
  input  plki_pkg::div_side_t   side_i,
  output logic                  valid_o,
  output logic [31:0]           value_o,
  output logic [1:0]            source_o
);

  logic [plki_pkg::RATIO_BITS-1:0] ratio_eff;
  logic signed [32:0] diff;
  logic signed [50:0] prod_d;
  logic signed [50:0] prod_q;
  logic               v_q;
  logic               interp_q;
  logic [1:0]         src_q;
  logic [31:0]        val_q;
  logic [31:0]        ga_q;
  logic signed [51:0] acc;
  logic               out_v_q;
  logic [31:0]        out_val_q;
  logic [1:0]         out_src_q;

  // a + r*(b-a) equals (1-r)*a + r*b
  always_comb begin
    ratio_eff = side_i.use_ratio ? ratio_i : '0;
    diff      = $signed({side_i.gb[31], side_i.gb}) - $signed({side_i.ga[31], side_i.ga});
    prod_d    = diff * $signed({1'b0, ratio_eff});
  end

  // add half an lsb, then arithmetic shift gives round half up
  assign acc = $signed({{4{ga_q[31]}}, ga_q, 16'h0000}) + $signed({prod_q[50], prod_q})
               + 52'sd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= valid_i;
      out_v_q <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= prod_d;
      interp_q  <= side_i.interp;
      src_q     <= side_i.src;
      val_q     <= side_i.val;
      ga_q      <= side_i.ga;
      out_val_q <= interp_q ? acc[47:16] : val_q;
      out_src_q <= src_q;
    end
  end

  assign valid_o  = out_v_q;
  assign value_o  = out_val_q;
  assign source_o = out_src_q;

endmodule
